// ----- rtl/pkclt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkclt_pkg
// Shared types and constants of the per-key count limiter table.
// ----------------------------------------------------------------------------
package pkclt_pkg;

  localparam int KEY_W             = 16;
  localparam int CNT_W             = 16;
  localparam int CHG_W             = 8;
  localparam int LIM_W             = 15;
  localparam int ENTRY_W           = 1 + KEY_W + CNT_W;
  localparam int DEF_TABLE_ENTRIES = 64;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_OVER = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_UPDATE
  } state_e;

  // One table entry as it sits in the memory.
  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [CNT_W-1:0] count;
  } entry_t;

endpackage

// ----- rtl/pkclt_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkclt_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module pkclt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/per_key_count_limiter_table_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_key_count_limiter_table_top
// Table of user keys with signed task counts, charged and limited per request.
// ----------------------------------------------------------------------------
// Usage:
//   A request (user_key_i, charge_i, count_limit_i) is taken at a rising edge
//   with start high and busy low. busy stays high while the request is worked.
//   The table memory is scanned one entry per cycle through its single read
//   port and a single key comparator, and busy stays high through the scan
//   and the update step; the result is registered from the update step onto
//   status_o and count_after_o, marked by done_o for exactly one cycle.
//   A new request may be started in the cycle in which done_o is high; no
//   new request is taken while a request is worked.
//   The receiver cannot stall: each result is taken in its done_o cycle.
//   After reset the block sweeps the memory to mark every entry free, one
//   entry a cycle; busy is high meanwhile.
//   Free entries are taken lowest index first; an update to zero frees an entry.
// ----------------------------------------------------------------------------
module per_key_count_limiter_table_top
  import pkclt_pkg::*;
#(
  parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic [KEY_W-1:0]        user_key_i,
  input  logic signed [CHG_W-1:0] charge_i,
  input  logic [LIM_W-1:0]        count_limit_i,
  output logic                    done_o,
  output logic [1:0]              status_o,
  output logic signed [CNT_W-1:0] count_after_o
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  state_e state_q, state_d;

  logic [IDX_W-1:0] clr_idx_q, clr_idx_d;
  logic [IDX_W-1:0] rd_idx_q, rd_idx_d;
  logic             issue_q, issue_d;
  logic             cmp_vld_q, cmp_vld_d;
  logic [IDX_W-1:0] cmp_idx_q, cmp_idx_d;
  logic             hit_found_q, hit_found_d;
  logic [IDX_W-1:0] hit_idx_q, hit_idx_d;
  logic [CNT_W-1:0] hit_cnt_q, hit_cnt_d;
  logic             free_found_q, free_found_d;
  logic [IDX_W-1:0] free_idx_q, free_idx_d;
  logic             done_q, done_d;
  logic [1:0]       status_q, status_d;
  logic [CNT_W-1:0] after_q, after_d;

  logic [KEY_W-1:0] key_q;
  logic [CHG_W-1:0] chg_q;
  logic [LIM_W-1:0] lim_q;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  entry_t           ram_wdata;
  logic             ram_re;
  entry_t           ram_rdata;

  logic               accept;
  logic               key_match;
  logic signed [CNT_W:0] new_cnt;
  logic               over_lim;
  logic               sat_low;
  logic [CNT_W-1:0]   stored_cnt;

  assign accept = start && !busy;

  pkclt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (rd_idx_q),
    .rdata_o (ram_rdata)
  );

  // The key comparator is the one unit the scan reuses on every entry.
  assign key_match = ram_rdata.valid && (ram_rdata.key == key_q);

  // Update arithmetic on the held count, one wider to see overflow.
  assign new_cnt  = $signed({hit_cnt_q[CNT_W-1], hit_cnt_q})
                  + $signed({{(CNT_W+1-CHG_W){chg_q[CHG_W-1]}}, chg_q});
  assign over_lim = new_cnt > $signed({2'b00, lim_q});
  assign sat_low  = new_cnt < $signed({1'b1, 1'b1, {(CNT_W-1){1'b0}}});
  assign stored_cnt = sat_low ? {1'b1, {(CNT_W-1){1'b0}}} : new_cnt[CNT_W-1:0];

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (clr_idx_q == LAST_IDX) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start) state_d = S_SCAN;
      end
      S_SCAN: begin
        if (cmp_vld_q && (cmp_idx_q == LAST_IDX)) state_d = S_UPDATE;
      end
      S_UPDATE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Outputs and datapath control.
  always_comb begin
    busy         = (state_q != S_IDLE);
    clr_idx_d    = clr_idx_q;
    rd_idx_d     = rd_idx_q;
    issue_d      = 1'b0;
    cmp_vld_d    = 1'b0;
    cmp_idx_d    = cmp_idx_q;
    hit_found_d  = hit_found_q;
    hit_idx_d    = hit_idx_q;
    hit_cnt_d    = hit_cnt_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    done_d       = 1'b0;
    status_d     = status_q;
    after_d      = after_q;
    ram_we       = 1'b0;
    ram_waddr    = clr_idx_q;
    ram_wdata    = '0;
    ram_re       = 1'b0;
    case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        clr_idx_d = clr_idx_q + 1'b1;
      end
      S_IDLE: begin
        if (start) begin
          rd_idx_d     = '0;
          issue_d      = 1'b1;
          hit_found_d  = 1'b0;
          free_found_d = 1'b0;
        end
      end
      S_SCAN: begin
        if (issue_q) begin
          ram_re    = 1'b1;
          cmp_vld_d = 1'b1;
          cmp_idx_d = rd_idx_q;
          if (rd_idx_q != LAST_IDX) begin
            rd_idx_d = rd_idx_q + 1'b1;
            issue_d  = 1'b1;
          end
        end
        if (cmp_vld_q) begin
          if (key_match && !hit_found_q) begin
            hit_found_d = 1'b1;
            hit_idx_d   = cmp_idx_q;
            hit_cnt_d   = ram_rdata.count;
          end
          if (!ram_rdata.valid && !free_found_q) begin
            free_found_d = 1'b1;
            free_idx_d   = cmp_idx_q;
          end
        end
      end
      S_UPDATE: begin
        done_d = 1'b1;
        if (hit_found_q) begin
          ram_waddr = hit_idx_q;
          if (over_lim) begin
            status_d = ST_OVER;
            after_d  = hit_cnt_q;
          end else if (new_cnt == '0) begin
            // Count back to zero: the entry is freed.
            ram_we   = 1'b1;
            status_d = ST_OK;
            after_d  = '0;
          end else begin
            ram_we          = 1'b1;
            ram_wdata.valid = 1'b1;
            ram_wdata.key   = key_q;
            ram_wdata.count = stored_cnt;
            status_d        = ST_OK;
            after_d         = stored_cnt;
          end
        end else if (free_found_q) begin
          // New key: stored without a limit check.
          ram_we          = 1'b1;
          ram_waddr       = free_idx_q;
          ram_wdata.valid = 1'b1;
          ram_wdata.key   = key_q;
          ram_wdata.count = {{(CNT_W-CHG_W){chg_q[CHG_W-1]}}, chg_q};
          status_d        = ST_OK;
          after_d         = {{(CNT_W-CHG_W){chg_q[CHG_W-1]}}, chg_q};
        end else begin
          status_d = ST_FULL;
          after_d  = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_idx_q    <= '0;
      rd_idx_q     <= '0;
      issue_q      <= 1'b0;
      cmp_vld_q    <= 1'b0;
      cmp_idx_q    <= '0;
      hit_found_q  <= 1'b0;
      hit_idx_q    <= '0;
      free_found_q <= 1'b0;
      free_idx_q   <= '0;
      done_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      clr_idx_q    <= clr_idx_d;
      rd_idx_q     <= rd_idx_d;
      issue_q      <= issue_d;
      cmp_vld_q    <= cmp_vld_d;
      cmp_idx_q    <= cmp_idx_d;
      hit_found_q  <= hit_found_d;
      hit_idx_q    <= hit_idx_d;
      free_found_q <= free_found_d;
      free_idx_q   <= free_idx_d;
      done_q       <= done_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      key_q <= user_key_i;
      chg_q <= charge_i;
      lim_q <= count_limit_i;
    end
    hit_cnt_q <= hit_cnt_d;
    status_q  <= status_d;
    after_q   <= after_d;
  end

  assign done_o        = done_q;
  assign status_o      = status_q;
  assign count_after_o = after_q;

`ifndef SYNTHESIS
  a_done_after_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == S_UPDATE))
    else $error("result strobe without an update step");

  a_start_scans: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_SCAN) && issue_q && (rd_idx_q == '0))
    else $error("accepted request did not start a scan at entry zero");

  a_full_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == ST_FULL)) |-> (count_after_o == '0))
    else $error("table full result carries a nonzero count");

  a_over_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPDATE && hit_found_q && over_lim) |-> !ram_we)
    else $error("over limit request wrote the table");
`endif

endmodule
